// ===== rtl/cab_pkg.sv =====
// Shared types, constants and helpers for the clipped alpha blit engine.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package cab_pkg;

    localparam int PIX_W      = 32;
    localparam int COORD_W    = 12;
    localparam int SIZE_W     = 13;
    localparam int PLACE_W    = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;
    localparam int Q_DEPTH    = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PLACE_X       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PLACE_Y       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_MODE    = 3'd6;

    // One classified pixel pair on its way from the front to the back.
    typedef struct packed {
        logic [PIX_W-1:0]   source_pixel;
        logic [PIX_W-1:0]   dest_pixel;
        logic               blend_mode;
        logic [COORD_W-1:0] dest_x;
        logic [COORD_W-1:0] dest_y;
        logic [COORD_W-1:0] source_x;
        logic [COORD_W-1:0] source_y;
        logic               last;
    } t_item;

    // floor(x / 255) for x up to 255 * 255.
    function automatic logic [7:0] f_div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return t[15:8];
    endfunction

endpackage

// ===== rtl/cab_stream_if.sv =====
// Valid/ready stream interfaces for the pixel pair input and the result output.
// Depends on cab_pkg for the field widths.
`timescale 1ns / 1ps

interface cab_in_if import cab_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] source_pixel;
    logic [PIX_W-1:0] dest_pixel;

    modport source (output valid, output source_pixel, output dest_pixel, input ready);
    modport sink   (input valid, input source_pixel, input dest_pixel, output ready);
endinterface

interface cab_out_if import cab_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PIX_W-1:0]   out_pixel;
    logic [COORD_W-1:0] dest_x;
    logic [COORD_W-1:0] dest_y;
    logic [COORD_W-1:0] source_x;
    logic [COORD_W-1:0] source_y;
    logic               last;

    modport source (output valid, output out_pixel, output dest_x, output dest_y,
                    output source_x, output source_y, output last, input ready);
    modport sink   (input valid, input out_pixel, input dest_x, input dest_y,
                    input source_x, input source_y, input last, output ready);
endinterface

// ===== rtl/cab_front.sv =====
// Front end: configuration registers, clip region, raster counters.
// Accepts pixel pairs, tags them with coordinates and pushes them to the queue.
// Depends on cab_pkg and cab_stream_if.
`timescale 1ns / 1ps

module cab_front import cab_pkg::*; #(
    parameter int MAX_SIDE = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    cab_in_if.sink                i_pix,
    input  logic                  i_q_full,
    output logic                  o_q_push,
    output t_item                 o_q_item
);

    // Largest side that a 13-bit register can reach after clamping.
    localparam int SIDE_MAX = (MAX_SIDE < 8191) ? MAX_SIDE : 8191;
    localparam int SW       = $clog2(SIDE_MAX + 1);

    function automatic logic [SW-1:0] f_side(input logic [SIZE_W-1:0] v);
        if (int'(v) > MAX_SIDE) begin
            return SW'(SIDE_MAX);
        end
        return SW'(v);
    endfunction

    logic [SIZE_W-1:0]  r_dest_w, r_dest_h, r_src_w, r_src_h;
    logic [PLACE_W-1:0] r_place_x, r_place_y;
    logic               r_blend;

    // Registered clip region, refreshed in the cycle after any register write.
    logic               r_rgn_ok;
    logic [COORD_W-1:0] r_dx0, r_dy0, r_sx0, r_sy0;
    logic [SW-1:0]      r_w, r_h;
    logic               r_empty;

    logic [SW-1:0]      r_col, r_row;
    logic [SW-1:0]      n_col, n_row;

    logic signed [15:0] px, py, dx0, dy0, sx0, sy0, x_end, y_end, w16, h16;
    logic signed [15:0] dw16, dh16, sw16, sh16;
    logic               accept;
    logic               wrap, last_col, last_row;
    logic [SW-1:0]      cur_col, cur_row;
    logic [15:0]        col16, row16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_w  <= '0;
            r_dest_h  <= '0;
            r_src_w   <= '0;
            r_src_h   <= '0;
            r_place_x <= '0;
            r_place_y <= '0;
            r_blend   <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DEST_WIDTH:    r_dest_w  <= i_cfg_wdata[SIZE_W-1:0];
                CFG_DEST_HEIGHT:   r_dest_h  <= i_cfg_wdata[SIZE_W-1:0];
                CFG_SOURCE_WIDTH:  r_src_w   <= i_cfg_wdata[SIZE_W-1:0];
                CFG_SOURCE_HEIGHT: r_src_h   <= i_cfg_wdata[SIZE_W-1:0];
                CFG_PLACE_X:       r_place_x <= i_cfg_wdata[PLACE_W-1:0];
                CFG_PLACE_Y:       r_place_y <= i_cfg_wdata[PLACE_W-1:0];
                CFG_BLEND_MODE:    r_blend   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        px    = signed'({{2{r_place_x[PLACE_W-1]}}, r_place_x});
        py    = signed'({{2{r_place_y[PLACE_W-1]}}, r_place_y});
        dw16  = signed'(16'(f_side(r_dest_w)));
        dh16  = signed'(16'(f_side(r_dest_h)));
        sw16  = signed'(16'(f_side(r_src_w)));
        sh16  = signed'(16'(f_side(r_src_h)));
        dx0   = (px > 16'sd0) ? px : 16'sd0;
        dy0   = (py > 16'sd0) ? py : 16'sd0;
        sx0   = (px < 16'sd0) ? -px : 16'sd0;
        sy0   = (py < 16'sd0) ? -py : 16'sd0;
        x_end = (px + sw16 < dw16) ? px + sw16 : dw16;
        y_end = (py + sh16 < dh16) ? py + sh16 : dh16;
        w16   = x_end - dx0;
        h16   = y_end - dy0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rgn_ok <= 1'b0;
        end else begin
            r_rgn_ok <= !i_cfg_we;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx0   <= dx0[COORD_W-1:0];
        r_dy0   <= dy0[COORD_W-1:0];
        r_sx0   <= sx0[COORD_W-1:0];
        r_sy0   <= sy0[COORD_W-1:0];
        r_w     <= w16[SW-1:0];
        r_h     <= h16[SW-1:0];
        r_empty <= (w16 <= 16'sd0) || (h16 <= 16'sd0);
    end

    assign i_pix.ready = r_rgn_ok && !i_q_full;
    assign accept      = i_pix.valid && i_pix.ready;
    // An empty region swallows the transfer without producing a result.
    assign o_q_push    = accept && !r_empty;

    always_comb begin
        // Counters left outside a shrunken region restart at the origin.
        wrap     = (r_col >= r_w) || (r_row >= r_h);
        cur_col  = wrap ? '0 : r_col;
        cur_row  = wrap ? '0 : r_row;
        last_col = ({1'b0, cur_col} + 1'b1) == {1'b0, r_w};
        last_row = ({1'b0, cur_row} + 1'b1) == {1'b0, r_h};
        col16    = 16'(cur_col);
        row16    = 16'(cur_row);

        o_q_item.source_pixel = i_pix.source_pixel;
        o_q_item.dest_pixel   = i_pix.dest_pixel;
        o_q_item.blend_mode   = r_blend;
        o_q_item.dest_x       = r_dx0 + col16[COORD_W-1:0];
        o_q_item.dest_y       = r_dy0 + row16[COORD_W-1:0];
        o_q_item.source_x     = r_sx0 + col16[COORD_W-1:0];
        o_q_item.source_y     = r_sy0 + row16[COORD_W-1:0];
        o_q_item.last         = last_col && last_row;

        n_col = r_col;
        n_row = r_row;
        if (o_q_push) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : cur_row + 1'b1;
            end else begin
                n_col = cur_col + 1'b1;
                n_row = cur_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

`ifndef SYNTHESIS
    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_push && o_q_item.last) |=> (r_col == '0 && r_row == '0))
        else $error("raster counters did not restart after the last pixel");
`endif

endmodule

// ===== rtl/cab_fifo.sv =====
// Short queue of classified pixel pairs between the front and the back.
// Depends on cab_pkg for the entry type and depth.
`timescale 1ns / 1ps

module cab_fifo import cab_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_vld,
    output t_item o_item
);

    localparam int PW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_item         r_mem [Q_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full = (r_cnt == CW'(Q_DEPTH));
    assign o_vld  = (r_cnt != '0);
    assign o_item = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into a full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_vld)
        else $error("pop from an empty queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(Q_DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

// ===== rtl/cab_back.sv =====
// Back end: two-stage blend pipeline ending in the output register.
// Stage one forms the channel products; stage two divides by 255, sums and selects by blend mode.
// Depends on cab_pkg and cab_stream_if.
`timescale 1ns / 1ps

module cab_back import cab_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_vld,
    input  t_item   i_q_item,
    output logic    o_q_pop,
    cab_out_if.source o_res
);

    logic        r_s1_vld;
    t_item       r_s1_item;
    logic [15:0] r_prod_d [3];
    logic [15:0] r_prod_s [3];

    logic        r_out_vld;
    logic        out_load, s1_adv;
    logic [7:0]  alpha, chan [3];
    logic [PIX_W-1:0] pix;

    assign out_load = !r_out_vld || o_res.ready;
    assign s1_adv   = !r_s1_vld || out_load;
    assign o_q_pop  = i_q_vld && s1_adv;
    assign alpha    = i_q_item.source_pixel[31:24];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_s1_vld <= i_q_vld;
            end
            if (out_load) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s1_item <= i_q_item;
            for (int k = 0; k < 3; k++) begin
                r_prod_d[k] <= {8'd0, i_q_item.dest_pixel[8*k +: 8]} *
                               {8'd0, 8'hff - alpha};
                r_prod_s[k] <= {8'd0, i_q_item.source_pixel[8*k +: 8]} * {8'd0, alpha};
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            chan[k] = f_div255(r_prod_d[k]) + f_div255(r_prod_s[k]);
        end
        if (!r_s1_item.blend_mode) begin
            pix = r_s1_item.source_pixel;
        end else if (r_s1_item.source_pixel[31:24] == 8'd0) begin
            pix = r_s1_item.dest_pixel;
        end else begin
            pix = {r_s1_item.dest_pixel[31:24], chan[2], chan[1], chan[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_s1_vld) begin
            o_res.out_pixel <= pix;
            o_res.dest_x    <= r_s1_item.dest_x;
            o_res.dest_y    <= r_s1_item.dest_y;
            o_res.source_x  <= r_s1_item.source_x;
            o_res.source_y  <= r_s1_item.source_y;
            o_res.last      <= r_s1_item.last;
        end
    end

    assign o_res.valid = r_out_vld;

endmodule

// ===== rtl/clipped_alpha_blit.sv =====
// Clipped ARGB8888 blit engine. An accepted transfer is written into the queue, then
// passes the product stage register and the output register, where its result shows.
// Throughput: one pixel pair per cycle while input ready is high and the output is ready,
// set by the raster counters and the pipelined blend.
// Input ready drops for one cycle after each register write and after reset while
// the clip region is recomputed. Synchronous active-low reset clears counters,
// queue and pipeline; registers reset to zero with blend mode on.
`timescale 1ns / 1ps

module clipped_alpha_blit import cab_pkg::*; #(
    parameter int MAX_SIDE = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    cab_in_if.sink                i_pix,
    cab_out_if.source             o_res
);

    logic  q_push, q_pop, q_full, q_vld;
    t_item q_in_item, q_out_item;

    cab_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pix       (i_pix),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_item    (q_in_item)
    );

    cab_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_vld   (q_vld),
        .o_item  (q_out_item)
    );

    cab_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_vld  (q_vld),
        .i_q_item (q_out_item),
        .o_q_pop  (q_pop),
        .o_res    (o_res)
    );

`ifndef SYNTHESIS
    a_cfg_blocks_input: assert property (@(posedge i_clk)
        i_cfg_we |=> !i_pix.ready)
        else $error("transfer possible while the clip region is stale");
    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid right after reset");
`endif

endmodule
